// ===== design/lpr_pkg.sv =====
// lpr_pkg: shared widths, register indexes and reset values of the line pixel rasterizer
// no dependencies

package lpr_pkg;

   localparam int COORD_BITS_DEFAULT = 10;
   localparam int ADDR_BITS          = 16;
   localparam int BPR_BITS           = 8;
   localparam int DPB_BITS           = 4;
   localparam int SCREEN_BITS        = 10;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int CSR_DATA_BITS      = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRAPHIC_HOME  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BYTES_PER_ROW = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOTS_PER_BYTE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_HEIGHT = 3'd4;

   localparam logic                   CMD_START = 1'b0;
   localparam logic                   CMD_ADVANCE = 1'b1;

   localparam logic [ADDR_BITS-1:0]   HOME_RESET   = 16'd0;
   localparam logic [BPR_BITS-1:0]    BPR_RESET    = 8'd30;
   localparam logic [DPB_BITS-1:0]    DPB_RESET    = 4'd8;
   localparam logic [SCREEN_BITS-1:0] WIDTH_RESET  = 10'd240;
   localparam logic [SCREEN_BITS-1:0] HEIGHT_RESET = 10'd128;

   localparam logic [DPB_BITS-1:0]    FONT_MIN = 4'd6;
   localparam logic [DPB_BITS-1:0]    FONT_MAX = 4'd8;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SETUP  = 8'b0000_0010,
      ST_ORIENT = 8'b0000_0100,
      ST_STEP   = 8'b0000_1000,
      ST_MUL    = 8'b0001_0000,
      ST_DIV    = 8'b0010_0000,
      ST_SUMH   = 8'b0100_0000,
      ST_SUMQ   = 8'b1000_0000
   } state_type;

endpackage

// ===== design/line_pixel_rasterizer_core.sv =====
// line_pixel_rasterizer_core: bresenham line walker with display byte address and bit index
// depends on lpr_pkg; one shared 16-bit adder serves the row multiply and the address sums
// sequence: a start item passes setup and orient, an advance item the step state; both then
// run the 8-step shift-add row multiply, the COORD_BITS-step divider and the two address sums
// one item at a time: taken only when idle with no result held; an idle advance gives none
// reset: synchronous, control state cleared, registers back to their defaults, no clear pass

module line_pixel_rasterizer_core #(
   parameter int COORD_BITS = lpr_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [lpr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lpr_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_cmd,
   input  logic [COORD_BITS-1:0]                req_x_start,
   input  logic [COORD_BITS-1:0]                req_y_start,
   input  logic [COORD_BITS-1:0]                req_x_end,
   input  logic [COORD_BITS-1:0]                req_y_end,
   input  logic                                 req_draw,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [COORD_BITS-1:0]                rsp_pixel_x,
   output logic [COORD_BITS-1:0]                rsp_pixel_y,
   output logic                                 rsp_visible,
   output logic [lpr_pkg::ADDR_BITS-1:0]        rsp_byte_addr,
   output logic [2:0]                           rsp_bit_index,
   output logic                                 rsp_set_pixel,
   output logic                                 rsp_last_pixel
);

   import lpr_pkg::*;

   localparam int TWICE_BITS = COORD_BITS + 2;
   localparam int ERR_BITS   = COORD_BITS + 3;
   localparam int CMP_BITS   = (COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS;
   localparam int CNT_BITS   = $clog2((COORD_BITS > BPR_BITS) ? COORD_BITS : BPR_BITS);
   localparam logic [CNT_BITS-1:0] MUL_LAST = CNT_BITS'(BPR_BITS - 1);
   localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(COORD_BITS - 1);

   // configuration
   logic [ADDR_BITS-1:0]   home_ff;
   logic [BPR_BITS-1:0]    bpr_ff;
   logic [DPB_BITS-1:0]    dpb_ff;
   logic [SCREEN_BITS-1:0] width_ff;
   logic [SCREEN_BITS-1:0] height_ff;

   // sequencer and walk state
   state_type              state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   line_active_ff, line_active_in;
   logic [COORD_BITS-1:0]  cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0]  cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0]  goal_x_ff, goal_x_in;
   logic [COORD_BITS-1:0]  goal_y_ff, goal_y_in;
   logic [TWICE_BITS-1:0]  twice_dx_ff, twice_dx_in;
   logic [TWICE_BITS-1:0]  twice_dy_ff, twice_dy_in;
   logic [ERR_BITS-1:0]    error_ff, error_in;
   logic                   step_x_neg_ff, step_x_neg_in;
   logic                   step_y_neg_ff, step_y_neg_in;
   logic                   x_major_ff, x_major_in;
   logic                   draw_ff, draw_in;
   logic                   last_ff, last_in;

   // shared arithmetic
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [ADDR_BITS-1:0]   acc_ff, acc_in;
   logic [BPR_BITS-1:0]    mul_ff, mul_in;
   logic [COORD_BITS-1:0]  quo_ff, quo_in;
   logic [2:0]             rem_ff, rem_in;
   logic [2:0]             bit_ff, bit_in;

   logic [ADDR_BITS-1:0]   add_a, add_b, add_sum;
   logic [DPB_BITS-1:0]    font_w;
   logic [DPB_BITS-1:0]    rem_shift;
   logic [DPB_BITS-1:0]    rem_diff;
   logic                   rem_ge;
   logic [COORD_BITS:0]    diff_x, diff_y;
   logic [COORD_BITS:0]    abs_x, abs_y;
   logic [ERR_BITS-1:0]    err_step;
   logic                   in_accept;

   assign in_accept = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;

   // font width clamp
   always_comb begin
      if (dpb_ff < FONT_MIN) begin
         font_w = FONT_MIN;
      end else if (dpb_ff > FONT_MAX) begin
         font_w = FONT_MAX;
      end else begin
         font_w = dpb_ff;
      end
   end

   // shared adder operand select
   always_comb begin
      add_a = '0;
      add_b = '0;
      case (state_ff)
         ST_MUL: begin
            add_a = {acc_ff[ADDR_BITS-2:0], 1'b0};
            add_b = mul_ff[BPR_BITS-1] ? ADDR_BITS'(cur_y_ff) : '0;
         end
         ST_SUMH: begin
            add_a = acc_ff;
            add_b = home_ff;
         end
         ST_SUMQ: begin
            add_a = acc_ff;
            add_b = ADDR_BITS'(quo_ff);
         end
         default: begin
            add_a = '0;
            add_b = '0;
         end
      endcase
   end
   assign add_sum = add_a + add_b;

   // restoring divide step
   assign rem_shift = {rem_ff, quo_ff[COORD_BITS-1]};
   assign rem_ge    = rem_shift >= font_w;
   assign rem_diff  = rem_shift - font_w;

   // endpoint deltas
   assign diff_x = {1'b0, goal_x_ff} - {1'b0, cur_x_ff};
   assign diff_y = {1'b0, goal_y_ff} - {1'b0, cur_y_ff};
   assign abs_x  = diff_x[COORD_BITS] ? (~diff_x + 1'b1) : diff_x;
   assign abs_y  = diff_y[COORD_BITS] ? (~diff_y + 1'b1) : diff_y;

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff;
      line_active_in = line_active_ff;
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      goal_x_in      = goal_x_ff;
      goal_y_in      = goal_y_ff;
      twice_dx_in    = twice_dx_ff;
      twice_dy_in    = twice_dy_ff;
      error_in       = error_ff;
      step_x_neg_in  = step_x_neg_ff;
      step_y_neg_in  = step_y_neg_ff;
      x_major_in     = x_major_ff;
      draw_in        = draw_ff;
      last_in        = last_ff;
      cnt_in         = cnt_ff;
      acc_in         = acc_ff;
      mul_in         = mul_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      bit_in         = bit_ff;
      err_step       = error_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (in_accept) begin
               if (req_cmd == CMD_START) begin
                  cur_x_in  = req_x_start;
                  cur_y_in  = req_y_start;
                  goal_x_in = req_x_end;
                  goal_y_in = req_y_end;
                  draw_in   = req_draw;
                  state_in  = ST_SETUP;
               end else begin
                  state_in = ST_STEP;
               end
            end
         end
         ST_SETUP: begin
            step_x_neg_in = diff_x[COORD_BITS];
            step_y_neg_in = diff_y[COORD_BITS];
            twice_dx_in   = {abs_x[COORD_BITS-1:0], 1'b0} & {TWICE_BITS{1'b1}};
            twice_dy_in   = {abs_y[COORD_BITS-1:0], 1'b0} & {TWICE_BITS{1'b1}};
            state_in      = ST_ORIENT;
         end
         ST_ORIENT: begin
            x_major_in = twice_dx_ff > twice_dy_ff;
            if (twice_dx_ff > twice_dy_ff) begin
               error_in = ERR_BITS'(twice_dy_ff) - ERR_BITS'(twice_dx_ff >> 1);
               last_in  = cur_x_ff == goal_x_ff;
            end else begin
               error_in = ERR_BITS'(twice_dx_ff) - ERR_BITS'(twice_dy_ff >> 1);
               last_in  = cur_y_ff == goal_y_ff;
            end
            line_active_in = (twice_dx_ff > twice_dy_ff) ? (cur_x_ff != goal_x_ff)
                                                         : (cur_y_ff != goal_y_ff);
            cnt_in   = '0;
            acc_in   = '0;
            mul_in   = bpr_ff;
            quo_in   = cur_x_ff;
            rem_in   = '0;
            state_in = ST_MUL;
         end
         ST_STEP: begin
            if (!line_active_ff) begin
               state_in = ST_IDLE;
            end else begin
               if (x_major_ff) begin
                  if (!error_ff[ERR_BITS-1]) begin
                     cur_y_in = step_y_neg_ff ? (cur_y_ff - 1'b1) : (cur_y_ff + 1'b1);
                     err_step = error_ff - ERR_BITS'(twice_dx_ff);
                  end
                  cur_x_in = step_x_neg_ff ? (cur_x_ff - 1'b1) : (cur_x_ff + 1'b1);
                  error_in = err_step + ERR_BITS'(twice_dy_ff);
                  last_in  = cur_x_in == goal_x_ff;
               end else begin
                  if (!error_ff[ERR_BITS-1]) begin
                     cur_x_in = step_x_neg_ff ? (cur_x_ff - 1'b1) : (cur_x_ff + 1'b1);
                     err_step = error_ff - ERR_BITS'(twice_dy_ff);
                  end
                  cur_y_in = step_y_neg_ff ? (cur_y_ff - 1'b1) : (cur_y_ff + 1'b1);
                  error_in = err_step + ERR_BITS'(twice_dx_ff);
                  last_in  = cur_y_in == goal_y_ff;
               end
               line_active_in = !last_in;
               cnt_in   = '0;
               acc_in   = '0;
               mul_in   = bpr_ff;
               quo_in   = cur_x_in;
               rem_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            acc_in = add_sum;
            mul_in = {mul_ff[BPR_BITS-2:0], 1'b0};
            if (cnt_ff == MUL_LAST) begin
               cnt_in   = '0;
               state_in = ST_DIV;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIV: begin
            rem_in = rem_ge ? rem_diff[2:0] : rem_shift[2:0];
            quo_in = {quo_ff[COORD_BITS-2:0], rem_ge};
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = '0;
               state_in = ST_SUMH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SUMH: begin
            acc_in   = add_sum;
            state_in = ST_SUMQ;
         end
         ST_SUMQ: begin
            acc_in       = add_sum;
            bit_in       = 3'(font_w - DPB_BITS'(1) - DPB_BITS'(rem_ff));
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         line_active_ff <= 1'b0;
         home_ff        <= HOME_RESET;
         bpr_ff         <= BPR_RESET;
         dpb_ff         <= DPB_RESET;
         width_ff       <= WIDTH_RESET;
         height_ff      <= HEIGHT_RESET;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         line_active_ff <= line_active_in;
         if (csr_we) begin
            case (csr_index)
               CSR_GRAPHIC_HOME:  home_ff   <= csr_wdata[ADDR_BITS-1:0];
               CSR_BYTES_PER_ROW: bpr_ff    <= csr_wdata[BPR_BITS-1:0];
               CSR_DOTS_PER_BYTE: dpb_ff    <= csr_wdata[DPB_BITS-1:0];
               CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata[SCREEN_BITS-1:0];
               CSR_SCREEN_HEIGHT: height_ff <= csr_wdata[SCREEN_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      goal_x_ff     <= goal_x_in;
      goal_y_ff     <= goal_y_in;
      twice_dx_ff   <= twice_dx_in;
      twice_dy_ff   <= twice_dy_in;
      error_ff      <= error_in;
      step_x_neg_ff <= step_x_neg_in;
      step_y_neg_ff <= step_y_neg_in;
      x_major_ff    <= x_major_in;
      draw_ff       <= draw_in;
      last_ff       <= last_in;
      cnt_ff        <= cnt_in;
      acc_ff        <= acc_in;
      mul_ff        <= mul_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      bit_ff        <= bit_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_x    = cur_x_ff;
   assign rsp_pixel_y    = cur_y_ff;
   assign rsp_visible    = (CMP_BITS'(cur_x_ff) < CMP_BITS'(width_ff)) &&
                           (CMP_BITS'(cur_y_ff) < CMP_BITS'(height_ff));
   assign rsp_byte_addr  = acc_ff;
   assign rsp_bit_index  = bit_ff;
   assign rsp_set_pixel  = draw_ff;
   assign rsp_last_pixel = last_ff;

endmodule

// ===== verif/tb_line_pixel_rasterizer_core.sv =====
// tb_line_pixel_rasterizer_core: self-checking testbench for the line pixel rasterizer core
// depends on lpr_pkg and line_pixel_rasterizer_core; predicts each pixel of the line walk
// and checks every result item in order under random idling on both channels

module tb_line_pixel_rasterizer_core;

   import lpr_pkg::*;

   localparam int COORD       = COORD_BITS_DEFAULT;
   localparam int SETTLE      = COORD + 30;
   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic [COORD-1:0]     x;
      logic [COORD-1:0]     y;
      logic                 visible;
      logic [ADDR_BITS-1:0] byte_addr;
      logic [2:0]           bit_index;
      logic                 set_pixel;
      logic                 last_pixel;
   } pixel_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_cmd;
   logic [COORD-1:0]          req_x_start;
   logic [COORD-1:0]          req_y_start;
   logic [COORD-1:0]          req_x_end;
   logic [COORD-1:0]          req_y_end;
   logic                      req_draw;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [COORD-1:0]          rsp_pixel_x;
   logic [COORD-1:0]          rsp_pixel_y;
   logic                      rsp_visible;
   logic [ADDR_BITS-1:0]      rsp_byte_addr;
   logic [2:0]                rsp_bit_index;
   logic                      rsp_set_pixel;
   logic                      rsp_last_pixel;

   // register copies
   logic [ADDR_BITS-1:0]   cfg_home;
   logic [BPR_BITS-1:0]    cfg_bpr;
   logic [DPB_BITS-1:0]    cfg_dots;
   logic [SCREEN_BITS-1:0] cfg_width;
   logic [SCREEN_BITS-1:0] cfg_height;

   // line walk state
   logic [COORD-1:0]  pos_x, pos_y, goal_x, goal_y;
   logic [COORD+1:0]  dbl_dx, dbl_dy;
   logic signed [COORD+2:0] err_acc;
   logic              neg_x, neg_y, along_x, line_live, set_latched;

   pixel_type pending_pixels[$];

   bit feed_idle_en;
   bit sink_idle_en;
   int sink_hold;
   int n_items, n_starts, n_advances, n_checked, n_clipped, n_settings, n_failures;

   line_pixel_rasterizer_core #(
      .COORD_BITS(COORD)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_x_start   (req_x_start),
      .req_y_start   (req_y_start),
      .req_x_end     (req_x_end),
      .req_y_end     (req_y_end),
      .req_draw      (req_draw),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_x   (rsp_pixel_x),
      .rsp_pixel_y   (rsp_pixel_y),
      .rsp_visible   (rsp_visible),
      .rsp_byte_addr (rsp_byte_addr),
      .rsp_bit_index (rsp_bit_index),
      .rsp_set_pixel (rsp_set_pixel),
      .rsp_last_pixel(rsp_last_pixel)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 45);
   endfunction

   function automatic void next_line_pixel(input logic cmd, input logic [COORD-1:0] xs, ys,
                                           input logic [COORD-1:0] xe, ye,
                                           input logic draw_flag);
      int dx, dy, font, addr;
      bit at_goal;
      pixel_type px;
      if (cmd == CMD_START) begin
         n_starts++;
         goal_x = xe;
         goal_y = ye;
         set_latched = draw_flag;
         dx = int'(xe) - int'(xs);
         dy = int'(ye) - int'(ys);
         neg_x = dx < 0;
         neg_y = dy < 0;
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         dbl_dx = (COORD+2)'(2 * dx);
         dbl_dy = (COORD+2)'(2 * dy);
         along_x = dbl_dx > dbl_dy;
         err_acc = along_x ? (COORD+3)'(2 * dy - dx) : (COORD+3)'(2 * dx - dy);
         pos_x = xs;
         pos_y = ys;
         at_goal = along_x ? (pos_x == goal_x) : (pos_y == goal_y);
      end else begin
         n_advances++;
         if (!line_live) return;
         if (along_x) begin
            if (err_acc >= 0) begin
               pos_y = neg_y ? pos_y - 1'b1 : pos_y + 1'b1;
               err_acc = err_acc - $signed({1'b0, dbl_dx});
            end
            pos_x = neg_x ? pos_x - 1'b1 : pos_x + 1'b1;
            err_acc = err_acc + $signed({1'b0, dbl_dy});
            at_goal = pos_x == goal_x;
         end else begin
            if (err_acc >= 0) begin
               pos_x = neg_x ? pos_x - 1'b1 : pos_x + 1'b1;
               err_acc = err_acc - $signed({1'b0, dbl_dy});
            end
            pos_y = neg_y ? pos_y - 1'b1 : pos_y + 1'b1;
            err_acc = err_acc + $signed({1'b0, dbl_dx});
            at_goal = pos_y == goal_y;
         end
      end
      line_live = !at_goal;
      // font width saturates to the supported range
      font = (cfg_dots < FONT_MIN) ? int'(FONT_MIN) :
             (cfg_dots > FONT_MAX) ? int'(FONT_MAX) : int'(cfg_dots);
      addr = int'(cfg_home) + int'(pos_y) * int'(cfg_bpr) + int'(pos_x) / font;
      px.x          = pos_x;
      px.y          = pos_y;
      px.visible    = (pos_x < cfg_width) && (pos_y < cfg_height);
      px.byte_addr  = addr[ADDR_BITS-1:0];
      px.bit_index  = 3'(font - 1 - int'(pos_x) % font);
      px.set_pixel  = set_latched;
      px.last_pixel = at_goal;
      pending_pixels.push_back(px);
      n_items++;
   endfunction

   function automatic void log_failure(input string what, input pixel_type want,
                                       input pixel_type got);
      n_failures++;
      if (n_failures <= 10)
         $display("%s: expected x=%0d y=%0d vis=%0b addr=%h bit=%0d set=%0b last=%0b, got x=%0d y=%0d vis=%0b addr=%h bit=%0d set=%0b last=%0b",
                  what, want.x, want.y, want.visible, want.byte_addr, want.bit_index,
                  want.set_pixel, want.last_pixel, got.x, got.y, got.visible, got.byte_addr,
                  got.bit_index, got.set_pixel, got.last_pixel);
   endfunction

   always @(posedge clock) begin : pixel_checker
      pixel_type want;
      pixel_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_pixel_x, rsp_pixel_y, rsp_visible, rsp_byte_addr, rsp_bit_index,
                 rsp_set_pixel, rsp_last_pixel};
         if (!got.visible) n_clipped++;
         if (pending_pixels.size() == 0) begin
            log_failure("unexpected item", '0, got);
         end else begin
            want = pending_pixels.pop_front();
            if (got !== want) log_failure("pixel mismatch", want, got);
            n_checked++;
         end
      end
   end

   initial begin : result_sink
      int stall;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = 0;
         if (sink_hold > 0) begin
            stall = sink_hold;
            sink_hold = 0;
         end else if (sink_idle_en) begin
            stall = idle_gap();
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d pixels still pending", cycles,
               pending_pixels.size());
      $display("TEST FAILED");
      $finish;
   end

   task automatic send_item(input logic cmd, input logic [COORD-1:0] xs, ys, xe, ye,
                            input logic draw_flag);
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_x_start <= xs;
      req_y_start <= ys;
      req_x_end   <= xe;
      req_y_end   <= ye;
      req_draw    <= draw_flag;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      next_line_pixel(cmd, xs, ys, xe, ye, draw_flag);
   endtask

   task automatic sender_pause();
      int g;
      if (!feed_idle_en) return;
      g = idle_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic send_advance();
      send_item(CMD_ADVANCE, COORD'($urandom), COORD'($urandom), COORD'($urandom),
                COORD'($urandom), 1'($urandom));
      sender_pause();
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic write_settings(input logic [ADDR_BITS-1:0] home, input logic [BPR_BITS-1:0] bpr,
                                 input logic [DPB_BITS-1:0] dots,
                                 input logic [SCREEN_BITS-1:0] width, height);
      write_reg(CSR_GRAPHIC_HOME, home);
      write_reg(CSR_BYTES_PER_ROW, CSR_DATA_BITS'(bpr));
      write_reg(CSR_DOTS_PER_BYTE, CSR_DATA_BITS'(dots));
      write_reg(CSR_SCREEN_WIDTH, CSR_DATA_BITS'(width));
      write_reg(CSR_SCREEN_HEIGHT, CSR_DATA_BITS'(height));
      csr_we     <= 1'b0;
      cfg_home   = home;
      cfg_bpr    = bpr;
      cfg_dots   = dots;
      cfg_width  = width;
      cfg_height = height;
      n_settings++;
   endtask

   function automatic logic [SCREEN_BITS-1:0] pick_span();
      if ($urandom_range(0, 3) == 0) return SCREEN_BITS'($urandom_range(0, 1023));
      return SCREEN_BITS'($urandom_range(200, 1023));
   endfunction

   task automatic write_random_settings();
      logic [DPB_BITS-1:0] dots;
      dots = ($urandom_range(0, 3) == 0) ? DPB_BITS'($urandom_range(0, 15))
                                          : DPB_BITS'($urandom_range(6, 8));
      write_settings(ADDR_BITS'($urandom), BPR_BITS'($urandom), dots, pick_span(), pick_span());
   endtask

   // start points favor the clip boundary and the coordinate extremes
   function automatic logic [COORD-1:0] pick_coord(input int limit);
      int v;
      case ($urandom_range(0, 2))
         0: v = $urandom_range(0, 1023);
         1: v = limit + $urandom_range(0, 6) - 3;
         default: v = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(1020, 1023);
      endcase
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return COORD'(v);
   endfunction

   function automatic logic [COORD-1:0] pick_end(input logic [COORD-1:0] c, input int span);
      int v;
      v = int'(c) + $urandom_range(0, 2 * span) - span;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return COORD'(v);
   endfunction

   task automatic walk_random_line();
      logic [COORD-1:0] xs, ys;
      int span, cap, steps;
      xs = pick_coord(int'(cfg_width));
      ys = pick_coord(int'(cfg_height));
      span = ($urandom_range(0, 9) == 0) ? 1023 : $urandom_range(0, 14);
      send_item(CMD_START, xs, ys, pick_end(xs, span), pick_end(ys, span), 1'($urandom));
      sender_pause();
      // some walks are cut short so the next start lands on an active line
      cap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 40;
      steps = 0;
      while (line_live && steps < cap) begin
         send_advance();
         steps++;
      end
      if ($urandom_range(0, 9) == 0) send_advance();
   endtask

   task automatic walk_fixed(input int xs, ys, xe, ye, input bit draw_flag, input int advances);
      send_item(CMD_START, COORD'(xs), COORD'(ys), COORD'(xe), COORD'(ye), draw_flag);
      sender_pause();
      repeat (advances) send_advance();
   endtask

   task automatic test_directed_walks();
      feed_idle_en = 1'b1;
      sink_idle_en = 1'b1;
      send_advance();
      walk_fixed(5, 5, 5, 5, 1'b1, 1);
      walk_fixed(0, 0, 3, 1, 1'b1, 3);
      walk_fixed(1023, 1023, 1021, 1018, 1'b0, 1);
      walk_fixed(238, 126, 241, 129, 1'b1, 3);
      walk_fixed(1023, 0, 0, 1023, 1'b0, 1);
      walk_fixed(9, 0, 7, 0, 1'b1, 2);
      walk_fixed(0, 3, 0, 5, 1'b0, 2);
      walk_fixed(1023, 1023, 1023, 1023, 1'b0, 0);
      walk_fixed(0, 1023, 1, 1023, 1'b1, 1);
      wait_idle();
   endtask

   task automatic test_config_extremes();
      write_settings(16'hFFFF, 8'd255, 4'd0, 10'd1023, 10'd1023);
      repeat (3) walk_random_line();
      wait_idle();
      write_settings(16'h0000, 8'd0, 4'd15, 10'd0, 10'd1);
      repeat (3) walk_random_line();
      wait_idle();
      write_settings(16'h8000, 8'd128, 4'd7, 10'd1, 10'd0);
      repeat (3) walk_random_line();
      wait_idle();
      write_settings(16'h7FFF, 8'd1, 4'd6, 10'd512, 10'd512);
      repeat (3) walk_random_line();
      wait_idle();
      write_settings(16'h1234, 8'd127, 4'd9, 10'd240, 10'd128);
      repeat (3) walk_random_line();
      wait_idle();
      write_settings(16'hFFF0, 8'd30, 4'd5, 10'd320, 10'd240);
      repeat (3) walk_random_line();
      wait_idle();
   endtask

   task automatic test_output_backpressure();
      int steps;
      feed_idle_en = 1'b0;
      sink_hold = 400;
      send_item(CMD_START, 10'd100, 10'd50, 10'd130, 10'd60, 1'b1);
      steps = 0;
      while (line_live && steps < 20) begin
         send_advance();
         steps++;
      end
      wait_idle();
   endtask

   task automatic test_random_lines();
      int target;
      for (int phase = 0; phase < 5; phase++) begin
         write_random_settings();
         feed_idle_en = (phase % 4 == 0) || (phase % 4 == 1);
         sink_idle_en = (phase % 4 == 0) || (phase % 4 == 2);
         target = n_items + 95;
         while (n_items < target) begin
            walk_random_line();
            if ($urandom_range(0, 29) == 0) wait_idle();
         end
         wait_idle();
      end
   endtask

   initial begin : run
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      req_valid   = 1'b0;
      req_cmd     = CMD_START;
      req_x_start = '0;
      req_y_start = '0;
      req_x_end   = '0;
      req_y_end   = '0;
      req_draw    = 1'b0;
      cfg_home    = HOME_RESET;
      cfg_bpr     = BPR_RESET;
      cfg_dots    = DPB_RESET;
      cfg_width   = WIDTH_RESET;
      cfg_height  = HEIGHT_RESET;
      pos_x = '0; pos_y = '0; goal_x = '0; goal_y = '0;
      dbl_dx = '0; dbl_dy = '0; err_acc = '0;
      neg_x = 1'b0; neg_y = 1'b0; along_x = 1'b0; line_live = 1'b0; set_latched = 1'b0;
      feed_idle_en = 1'b0;
      sink_idle_en = 1'b0;
      sink_hold = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed_walks();
      test_config_extremes();
      test_output_backpressure();
      test_random_lines();

      $display("walked %0d pixel items (%0d starts, %0d advances) over %0d register settings",
               n_items, n_starts, n_advances, n_settings);
      $display("%0d results checked, %0d of them clipped, %0d failures",
               n_checked, n_clipped, n_failures);
      if (n_failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
